// ===== src/owm_pkg.sv =====
// Package with shared types and constants for the 1-Wire master.
`timescale 1ns / 1ps
package owm_pkg;
	typedef enum logic [2:0] {
		K_TICK = 3'd0, K_RESET = 3'd1, K_WBYTE = 3'd2, K_RBYTE = 3'd3,
		K_WBIT = 3'd4, K_RBIT = 3'd5, K_SFIRST = 3'd6, K_SNEXT = 3'd7
	} kind_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       line_level;
	} in_item_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  read_data;
		logic [63:0] rom_code;
		logic        last_device;
		logic        no_response;
	} out_item_t;

	localparam logic [7:0] SEARCH_CMD = 8'hF0;
	localparam logic [8:0] T_RREL = 9'd70;
	localparam logic [8:0] T_RWAIT = 9'd410;
	localparam logic [8:0] T_LOW1 = 9'd6;
	localparam logic [8:0] T_LOW0 = 9'd60;
	localparam logic [8:0] T_REL1 = 9'd64;
	localparam logic [8:0] T_REL0 = 9'd10;
	localparam logic [8:0] T_RSAMP = 9'd9;
	localparam logic [8:0] T_TAIL = 9'd55;
endpackage

// ===== src/onewire_master_with_rom_search.sv =====
// Top level of the 1-Wire bus master with ROM search.
//
// Input items on in_valid/in_ready carry a kind, a data byte and the sampled
// bus level. Kind 0 is a tick of one microsecond; kinds 1 to 7 start a reset
// pulse, byte or bit transfers, or one search-ROM pass when the master is idle
// and are ignored otherwise. Every item yields exactly one result item on
// out_valid/out_ready with the line drive, busy, done, read data, ROM code and
// search flags as they stand after that item.
// A two-entry queue takes items in front; the sequencer then handles one item
// per clock while the receiver does not stall, and its output register sends
// the result the next cycle, so a result passes the queue and then the output
// register. If the receiver stalls, the output register holds and the queue
// fills, then in_ready falls. bit_order is written through cfg_we/cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// Reset clears the queue, the sequencer and the output register at once.
`timescale 1ns / 1ps
module onewire_master_with_rom_search import owm_pkg::*; #(
	parameter int RESET_LOW_TICKS = 480
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	logic     order_q;
	logic     q_valid, q_ready;
	in_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= 1'b0;
		else if (cfg_we) order_q <= cfg_data;
	end

	owm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	owm_seq #(.RESET_LOW_TICKS(RESET_LOW_TICKS)) u_seq (
		.clk(clk), .arst_n(arst_n), .bit_order(order_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

// ===== src/owm_queue.sv =====
// Two-entry queue between the input front and the sequencer.
`timescale 1ns / 1ps
module owm_queue import owm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output in_item_t out_item
);
	in_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== src/owm_seq.sv =====
// Bus sequencer: timing phases, byte shifting and the ROM search.
`timescale 1ns / 1ps
module owm_seq import owm_pkg::*; #(
	parameter int RESET_LOW_TICKS = 480
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bit_order,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	typedef enum logic [2:0] {
		PH_IDLE, PH_RLOW, PH_RREL, PH_RWAIT, PH_LOW, PH_REL, PH_TAIL
	} phase_t;
	typedef enum logic [2:0] {
		JB_RESET, JB_WBYTE, JB_RBYTE, JB_WBIT, JB_RBIT, JB_SEARCH
	} job_t;
	typedef enum logic [2:0] {SS_RST, SS_CMD, SS_ID, SS_CMP, SS_DIR} stage_t;

	localparam logic [8:0] T_RLOW = 9'(RESET_LOW_TICKS);

	phase_t      ph_q;
	job_t        job_q;
	stage_t      stage_q;
	logic [8:0]  tmr_q;
	logic [6:0]  bcnt_q;
	logic [7:0]  shift_q, rbyte_q;
	logic [63:0] rom_q;
	logic [6:0]  ldisc_q, lzero_q;
	logic        found_q, idbit_q, isread_q, sbit_q, order_q, noresp_q;
	logic        ovalid_q;
	out_item_t   oitem_q;

	logic accept;
	assign in_ready  = !ovalid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign out_item  = oitem_q;

	function automatic logic [2:0] bpos(logic ord, logic [2:0] i);
		return ord ? 3'd7 - i : i;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		phase_t      ph;
		job_t        job;
		stage_t      stg;
		logic [8:0]  tmr;
		logic [6:0]  bc, ld, lz;
		logic [7:0]  sh, rb;
		logic [63:0] rom;
		logic        fnd, idb, isr, sb, ordl, nr, done, fin, dir, smp;
		logic [5:0]  k;
		if (!arst_n) begin
			ph_q <= PH_IDLE; job_q <= JB_RESET; stage_q <= SS_RST; tmr_q <= '0;
			bcnt_q <= '0; shift_q <= '0; rbyte_q <= '0; rom_q <= '0;
			ldisc_q <= '0; lzero_q <= '0; found_q <= 1'b0; idbit_q <= 1'b0;
			isread_q <= 1'b0; sbit_q <= 1'b0; order_q <= 1'b0; noresp_q <= 1'b0;
			ovalid_q <= 1'b0; oitem_q <= '0;
		end else begin
			if (!accept && out_ready) ovalid_q <= 1'b0;
			if (accept) begin
				ph = ph_q; job = job_q; stg = stage_q; tmr = tmr_q; bc = bcnt_q;
				sh = shift_q; rb = rbyte_q; rom = rom_q; ld = ldisc_q; lz = lzero_q;
				fnd = found_q; idb = idbit_q; isr = isread_q; sb = sbit_q;
				ordl = order_q; nr = noresp_q; done = 1'b0;
				if (in_item.kind == K_TICK) begin
					if (ph != PH_IDLE) begin
						if (tmr != 9'd0) tmr = tmr - 9'd1;
						if (tmr == 9'd0) begin
							fin = 1'b0;
							unique case (ph)
								PH_RLOW: begin ph = PH_RREL; tmr = T_RREL; end
								PH_RREL: begin ph = PH_RWAIT; tmr = T_RWAIT; end
								PH_LOW: begin
									ph = PH_REL;
									tmr = isr ? T_RSAMP : (sb ? T_REL1 : T_REL0);
								end
								PH_REL: begin
									if (isr) begin
										ph = PH_TAIL; tmr = T_TAIL; sb = in_item.line_level;
									end else fin = 1'b1;
								end
								PH_TAIL, PH_RWAIT: fin = 1'b1;
								default: ph = PH_IDLE;
							endcase
							if (fin) begin
								ph = PH_IDLE;
								smp = sb;
								done = 1'b1;
								case (job)
									JB_WBYTE: begin
										bc = bc + 7'd1;
										if (bc < 7'd8) begin
											done = 1'b0; isr = 1'b0; ph = PH_LOW;
											sb = sh[bpos(ordl, bc[2:0])];
										end
									end
									JB_RBYTE: begin
										sh[bpos(ordl, bc[2:0])] = sh[bpos(ordl, bc[2:0])] | smp;
										bc = bc + 7'd1;
										if (bc < 7'd8) begin
											done = 1'b0; isr = 1'b1; ph = PH_LOW;
										end else rb = sh;
									end
									JB_RBIT: rb = {7'd0, smp};
									JB_SEARCH: begin
										done = 1'b0;
										case (stg)
											SS_RST: begin
												stg = SS_CMD; bc = '0; isr = 1'b0;
												sb = SEARCH_CMD[0]; ph = PH_LOW;
											end
											SS_CMD: begin
												bc = bc + 7'd1;
												isr = 1'b0; ph = PH_LOW;
												if (bc < 7'd8) sb = SEARCH_CMD[bc[2:0]];
												else begin
													bc = 7'd1; stg = SS_ID; isr = 1'b1;
												end
											end
											SS_ID: begin
												idb = smp; stg = SS_CMP; isr = 1'b1; ph = PH_LOW;
											end
											SS_CMP: begin
												if (idb && smp) begin
													nr = 1'b1; ld = '0; fnd = 1'b0; done = 1'b1;
												end else begin
													k = 6'(bc - 7'd1);
													if (!idb && !smp) begin
														if (bc < ld) dir = rom[k];
														else dir = (bc == ld);
														if (!dir) lz = bc;
													end else dir = idb;
													rom[k] = dir;
													stg = SS_DIR; isr = 1'b0; sb = dir; ph = PH_LOW;
												end
											end
											default: begin
												if (bc >= 7'd64) begin
													ld = lz;
													if (lz == 7'd0) fnd = 1'b1;
													done = 1'b1;
												end else begin
													bc = bc + 7'd1; stg = SS_ID; isr = 1'b1; ph = PH_LOW;
												end
											end
										endcase
									end
									default: ;
								endcase
								if (ph == PH_LOW) tmr = (isr || sb) ? T_LOW1 : T_LOW0;
								if (done) begin ph = PH_IDLE; tmr = '0; end
							end
						end
					end
				end else if (ph == PH_IDLE) begin
					ordl = bit_order; bc = '0;
					case (in_item.kind)
						K_RESET: begin job = JB_RESET; ph = PH_RLOW; tmr = T_RLOW; end
						K_WBYTE: begin
							job = JB_WBYTE; sh = in_item.data; isr = 1'b0;
							sb = in_item.data[bpos(bit_order, 3'd0)]; ph = PH_LOW;
						end
						K_RBYTE: begin job = JB_RBYTE; sh = '0; isr = 1'b1; ph = PH_LOW; end
						K_WBIT: begin
							job = JB_WBIT; isr = 1'b0; sb = in_item.data[0]; ph = PH_LOW;
						end
						K_RBIT: begin job = JB_RBIT; isr = 1'b1; ph = PH_LOW; end
						default: begin
							if (in_item.kind == K_SFIRST || fnd) begin ld = '0; fnd = 1'b0; end
							job = JB_SEARCH; stg = SS_RST; lz = '0; idb = 1'b0; nr = 1'b0;
							ph = PH_RLOW; tmr = T_RLOW;
						end
					endcase
					if (ph == PH_LOW) tmr = (isr || sb) ? T_LOW1 : T_LOW0;
				end
				ph_q <= ph; job_q <= job; stage_q <= stg; tmr_q <= tmr; bcnt_q <= bc;
				shift_q <= sh; rbyte_q <= rb; rom_q <= rom; ldisc_q <= ld; lzero_q <= lz;
				found_q <= fnd; idbit_q <= idb; isread_q <= isr; sbit_q <= sb;
				order_q <= ordl; noresp_q <= nr;
				ovalid_q <= 1'b1;
				oitem_q.drive_low <= (ph == PH_RLOW) || (ph == PH_LOW);
				oitem_q.busy_res <= (ph != PH_IDLE);
				oitem_q.done_res <= done;
				oitem_q.read_data <= rb;
				oitem_q.rom_code <= rom;
				oitem_q.last_device <= fnd;
				oitem_q.no_response <= nr;
			end
		end
	end
endmodule
